>>> hdl/vtcs_pkg.sv
// Shared types, codes and sizes of the voxel terrain span generator.
package vtcs_pkg;

  localparam int SCREEN_COLUMNS = 320;
  localparam int SCREEN_ROWS = 200;

  localparam int COL_AW = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
  localparam int YW = 20;
  localparam int SHADE_W = 24;
  localparam int STEP_W = 25;
  localparam int DIV_STEPS = SHADE_W;
  localparam int DIV_CW = $clog2(DIV_STEPS + 1);

  localparam logic [7:0] TOP_RESET = 8'(SCREEN_ROWS);
  localparam logic [7:0] ROW_MAX = 8'(SCREEN_ROWS - 1);
  localparam logic signed [YW-1:0] ROW_HALF = YW'(SCREEN_ROWS / 2);

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [15:0] cell_index;
    logic [7:0] height_value;
    logic [7:0] color_value;
    logic [8:0] column;
    logic [23:0] pos_x;
    logic [23:0] pos_y;
    logic signed [12:0] eye_height;
    logic [14:0] depth_scale;
    logic [7:0] fade;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic [SHADE_W-1:0] shade;
    logic [7:0] top;
  } col_entry_t;

  typedef struct packed {
    logic start;
    logic signed [STEP_W-1:0] dividend;
    logic [YW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
    logic signed [STEP_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hdl/vtcs_front.sv
// Input side: accepts transactions, drops ignored ones and queues commands.
module vtcs_front (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [127:0] s_tdata,
  input  logic [1:0] s_tuser,
  input  logic enable,
  output logic q_valid,
  output vtcs_pkg::cmd_t q_cmd,
  input  logic q_pop
);

  vtcs_pkg::cmd_t slots [4];
  logic [1:0] wptr;
  logic [1:0] rptr;
  logic [2:0] count;
  vtcs_pkg::cmd_t cmd_in;
  logic keep;
  logic push;
  logic pop;

  always_comb begin
    cmd_in.op = s_tuser;
    cmd_in.cell_index = s_tdata[15:0];
    cmd_in.height_value = s_tdata[23:16];
    cmd_in.color_value = s_tdata[31:24];
    cmd_in.column = s_tdata[40:32];
    cmd_in.pos_x = s_tdata[64:41];
    cmd_in.pos_y = s_tdata[88:65];
    cmd_in.eye_height = s_tdata[101:89];
    cmd_in.depth_scale = s_tdata[116:102];
    cmd_in.fade = s_tdata[124:117];
  end

  assign keep = (s_tuser == vtcs_pkg::OP_LOAD) || (s_tuser == vtcs_pkg::OP_FRAME) ||
                ((s_tuser == vtcs_pkg::OP_SAMPLE) &&
                 ({1'b0, s_tdata[40:32]} < 10'(vtcs_pkg::SCREEN_COLUMNS)));
  assign s_tready = enable && (count != 3'd4);
  assign push = s_tvalid && s_tready && keep;
  assign q_valid = (count != 3'd0);
  assign pop = q_pop && q_valid;
  assign q_cmd = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 2'd1;
      end
      if (pop) begin
        rptr <= rptr + 2'd1;
      end
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

>>> hdl/vtcs_div.sv
// Bit-serial signed divider, truncating toward zero.
module vtcs_div (
  input  logic clk,
  input  logic rst,
  input  vtcs_pkg::div_req_t req,
  output vtcs_pkg::div_rsp_t rsp
);

  logic [vtcs_pkg::YW-1:0] rem;
  logic [vtcs_pkg::SHADE_W-1:0] quo;
  logic [vtcs_pkg::YW-1:0] den;
  logic [vtcs_pkg::DIV_CW-1:0] cnt;
  logic neg;
  logic busy;
  logic done;
  logic [vtcs_pkg::STEP_W-1:0] mag;
  logic [vtcs_pkg::YW:0] shifted;
  logic [vtcs_pkg::YW:0] trial;

  assign mag = req.dividend[vtcs_pkg::STEP_W-1] ? -req.dividend : req.dividend;
  assign shifted = {rem, quo[vtcs_pkg::SHADE_W-1]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[vtcs_pkg::STEP_W-1];
      quo <= mag[vtcs_pkg::SHADE_W-1:0];
      rem <= '0;
      den <= req.divisor;
    end else if (busy) begin
      if (!trial[vtcs_pkg::YW]) begin
        rem <= trial[vtcs_pkg::YW-1:0];
        quo <= {quo[vtcs_pkg::SHADE_W-2:0], 1'b1};
      end else begin
        rem <= shifted[vtcs_pkg::YW-1:0];
        quo <= {quo[vtcs_pkg::SHADE_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= vtcs_pkg::DIV_CW'(vtcs_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - vtcs_pkg::DIV_CW'(1);
        if (cnt == vtcs_pkg::DIV_CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.busy = busy;
  assign rsp.quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

>>> hdl/vtcs_back.sv
// Execution side: map memories, column state, interpolation, projection and span output.
module vtcs_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  vtcs_pkg::cmd_t q_cmd,
  output logic q_pop,
  output logic init_done,
  output logic m_tvalid,
  input  logic m_tready,
  output logic [87:0] m_tdata
);

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_READ = 4'd2;
  localparam logic [3:0] ST_BL1 = 4'd3;
  localparam logic [3:0] ST_BL2 = 4'd4;
  localparam logic [3:0] ST_PROJ = 4'd5;
  localparam logic [3:0] ST_CMP = 4'd6;
  localparam logic [3:0] ST_DIV = 4'd7;
  localparam logic [3:0] ST_OUT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  vtcs_pkg::cmd_t cur;
  logic [2:0] rd_cnt;
  logic [vtcs_pkg::COL_AW-1:0] clr_idx;

  logic [15:0] map_mem [65536];
  logic [15:0] map_rdata;
  logic [15:0] map_raddr;
  logic map_we;

  vtcs_pkg::col_entry_t col_mem [vtcs_pkg::SCREEN_COLUMNS];
  vtcs_pkg::col_entry_t col_rdata;
  vtcs_pkg::col_entry_t col_q;
  vtcs_pkg::col_entry_t col_wdata;
  logic [vtcs_pkg::COL_AW-1:0] col_waddr;
  logic col_we;

  logic [7:0] u0;
  logic [7:0] u1;
  logic [7:0] v0;
  logic [7:0] v1;
  logic [7:0] fa;
  logic [7:0] fb;
  logic [15:0] m [4];

  logic signed [17:0] top_h;
  logic signed [17:0] bot_h;
  logic signed [17:0] top_c;
  logic signed [17:0] bot_c;
  logic signed [26:0] blend_h;
  logic signed [26:0] blend_c;
  logic [7:0] h;
  logic [vtcs_pkg::SHADE_W-1:0] c;
  logic signed [13:0] h_rel;
  logic signed [29:0] prod;
  logic signed [vtcs_pkg::YW-1:0] y;

  logic signed [vtcs_pkg::YW-1:0] top_s;
  logic hit;
  logic [vtcs_pkg::SHADE_W-1:0] prev;
  logic [7:0] row0;
  logic [7:0] yc;
  logic signed [8:0] cnt_s;
  logic emit;

  logic [8:0] r_col;
  logic [7:0] r_row;
  logic [7:0] r_cnt;
  logic [vtcs_pkg::SHADE_W-1:0] r_prev;
  logic [7:0] r_fade;

  vtcs_pkg::div_req_t div_req;
  vtcs_pkg::div_rsp_t div_rsp;
  logic out_load;

  vtcs_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign u0 = cur.pos_x[23:16];
  assign fa = cur.pos_x[15:8];
  assign v0 = cur.pos_y[23:16];
  assign fb = cur.pos_y[15:8];
  assign u1 = u0 + 8'd1;
  assign v1 = v0 + 8'd1;

  always_comb begin
    case (rd_cnt[1:0])
      2'd0: map_raddr = {v0, u0};
      2'd1: map_raddr = {v0, u1};
      2'd2: map_raddr = {v1, u0};
      default: map_raddr = {v1, u1};
    endcase
  end

  assign map_we = (state == ST_IDLE) && q_valid && (q_cmd.op == vtcs_pkg::OP_LOAD);

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[q_cmd.cell_index] <= {q_cmd.height_value, q_cmd.color_value};
    end
    map_rdata <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rdata <= col_mem[vtcs_pkg::COL_AW'(cur.column)];
  end

  always_comb begin
    top_s = $signed({{(vtcs_pkg::YW-8){1'b0}}, col_q.top});
    hit = y < top_s;
    prev = col_q.valid ? col_q.shade : c;
    row0 = (col_q.top > vtcs_pkg::ROW_MAX) ? vtcs_pkg::ROW_MAX : col_q.top;
    yc = y[vtcs_pkg::YW-1] ? 8'd0 : y[7:0];
    cnt_s = $signed({1'b0, row0}) - $signed({1'b0, yc});
    emit = hit && (cnt_s > 9'sd0);
  end

  always_comb begin
    col_we = 1'b0;
    col_waddr = vtcs_pkg::COL_AW'(cur.column);
    col_wdata.valid = 1'b1;
    col_wdata.shade = c;
    col_wdata.top = hit ? yc : col_q.top;
    if (state == ST_INIT) begin
      col_we = 1'b1;
      col_waddr = clr_idx;
      col_wdata.valid = 1'b0;
      col_wdata.shade = '0;
      col_wdata.top = vtcs_pkg::TOP_RESET;
    end else if (state == ST_CMP) begin
      col_we = 1'b1;
    end
  end

  assign div_req.start = (state == ST_CMP) && emit;
  assign div_req.dividend = $signed({1'b0, c}) - $signed({1'b0, prev});
  assign div_req.divisor = top_s - y;

  assign q_pop = (state == ST_IDLE) && q_valid;
  assign init_done = (state != ST_INIT);
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (clr_idx == vtcs_pkg::COL_AW'(vtcs_pkg::SCREEN_COLUMNS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid && (q_cmd.op == vtcs_pkg::OP_FRAME)) begin
          state_next = ST_INIT;
        end else if (q_valid && (q_cmd.op == vtcs_pkg::OP_SAMPLE)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt == 3'd4) begin
          state_next = ST_BL1;
        end
      end
      ST_BL1: state_next = ST_BL2;
      ST_BL2: state_next = ST_PROJ;
      ST_PROJ: state_next = ST_CMP;
      ST_CMP: state_next = emit ? ST_DIV : ST_IDLE;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      clr_idx <= '0;
      rd_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        clr_idx <= clr_idx + vtcs_pkg::COL_AW'(1);
      end else begin
        clr_idx <= '0;
      end
      if (state == ST_READ) begin
        rd_cnt <= rd_cnt + 3'd1;
      end else begin
        rd_cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_cmd;
    end
    if ((state == ST_READ) && (rd_cnt != 3'd0)) begin
      m[rd_cnt[1:0] - 2'd1] <= map_rdata;
    end
    if ((state == ST_READ) && (rd_cnt == 3'd1)) begin
      col_q <= col_rdata;
    end
    if (state == ST_BL1) begin
      top_h <= $signed({10'd0, m[0][15:8]}) * 18'sd256 +
               $signed({10'd0, fa}) * ($signed({10'd0, m[1][15:8]}) -
                                       $signed({10'd0, m[0][15:8]}));
      bot_h <= $signed({10'd0, m[2][15:8]}) * 18'sd256 +
               $signed({10'd0, fa}) * ($signed({10'd0, m[3][15:8]}) -
                                       $signed({10'd0, m[2][15:8]}));
      top_c <= $signed({10'd0, m[0][7:0]}) * 18'sd256 +
               $signed({10'd0, fa}) * ($signed({10'd0, m[1][7:0]}) -
                                       $signed({10'd0, m[0][7:0]}));
      bot_c <= $signed({10'd0, m[2][7:0]}) * 18'sd256 +
               $signed({10'd0, fa}) * ($signed({10'd0, m[3][7:0]}) -
                                       $signed({10'd0, m[2][7:0]}));
    end
    if (state == ST_BL2) begin
      blend_h <= 27'(top_h) * 27'sd256 + $signed({19'd0, fb}) * 27'(bot_h - top_h);
      blend_c <= 27'(top_c) * 27'sd256 + $signed({19'd0, fb}) * 27'(bot_c - top_c);
    end
    if (state == ST_PROJ) begin
      y <= vtcs_pkg::YW'(prod >>> 11) + vtcs_pkg::ROW_HALF;
    end
    if (state == ST_CMP) begin
      r_col <= cur.column;
      r_row <= row0;
      r_cnt <= cnt_s[7:0];
      r_prev <= prev;
      r_fade <= cur.fade;
    end
  end

  assign h = blend_h[23:16];
  assign c = blend_c[23:0];
  assign h_rel = $signed({6'd0, h}) - 14'(cur.eye_height);
  assign prod = 30'(h_rel) * $signed({15'd0, cur.depth_scale});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, r_fade, div_rsp.quotient, r_prev, r_cnt, r_row, r_col};
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
    else $error("waiting for a divider that is not running");
  a_span_len: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ((r_cnt != 8'd0) && (r_row <= vtcs_pkg::ROW_MAX)))
    else $error("span with no pixels or row out of range");
  a_no_pop_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !q_pop)
    else $error("command taken during column clear");
`endif

endmodule

>>> hdl/voxel_terrain_column_spans_top.sv
// Top level of the voxel terrain span generator: command queue and execution engine.
// Order: a load is written to the map when the engine takes it from the command queue;
// a sample reads four map cells and its column, blends, projects and then updates its
// column; a sample with a span then waits for the divider and for the output to be free.
// Flow: the engine runs one command at a time, fed from a queue of four; a frame clears
// all 320 columns. Reset: synchronous; after reset a column clear runs with s_tready low.
module voxel_terrain_column_spans_top (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // cell_index, height_value, color_value, column, pos_x, pos_y, eye_height, depth_scale,
  // fade
  input  logic [127:0] s_tdata,
  // op
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // span_column, span_start_row, span_count, start_shade, shade_step, span_fade
  output logic [87:0] m_tdata
);

  logic q_valid;
  logic q_pop;
  logic init_done;
  vtcs_pkg::cmd_t q_cmd;

  vtcs_front u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .enable(init_done),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .q_pop(q_pop)
  );

  vtcs_back u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_cmd(q_cmd),
    .q_pop(q_pop),
    .init_done(init_done),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

endmodule
